/* hw/rtl/bbm_pkg.sv */
// Shared types, widths and constants for the binary blob moments block.
package bbm_pkg;

    localparam int BBM_MAX_DIM = 1024;

    localparam int PIX_W       = 8;
    localparam int COORD_W     = 10;
    localparam int WIDTH_REG_W = 11;
    localparam int AREA_W      = 21;
    localparam int SUM_W       = 31;
    localparam int SQ_W        = 41;
    localparam int SPREAD_W    = 61;
    localparam int CROSS_W     = 62;
    localparam int MUL_W       = 32;
    localparam int RES_W       = 288;
    localparam int PAD_W       = RES_W - AREA_W - 8 * COORD_W - 2 * SPREAD_W - CROSS_W;

    // restoring divide: quotient fits COORD_W bits, top bit weight
    localparam int DIV_SHIFT = COORD_W - 1;

    localparam logic [PIX_W-1:0]       OBJECT_PIXEL = 8'd255;
    localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET  = 11'd640;

    // frame-end sequence: load cycle plus one divide step per quotient bit
    localparam int CNT_W = 4;
    localparam logic [CNT_W-1:0] CALC_LAST = 4'd10;
    localparam logic [CNT_W-1:0] MUL_OPS   = 4'd9;

    // APB
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_IMAGE_WIDTH = 1'b0;  // word index paddr[2]

    typedef enum logic [1:0] {
        S_ACCUM,
        S_CALC,
        S_OUT
    } t_state;

    typedef enum logic [CNT_W-1:0] {
        OP_X_LO,
        OP_X_HI,
        OP_X_SQ,
        OP_Y_LO,
        OP_Y_HI,
        OP_Y_SQ,
        OP_XY_LO,
        OP_XY_HI,
        OP_XY_SQ
    } t_mul_op;

    typedef struct packed {
        logic    acc_en;
        logic    calc_load;
        logic    div_step;
        logic    mul_issue;
        t_mul_op mul_op;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
    } t_dp_stat;

    // first member is the MSB: area sits in the lowest bits of tdata
    typedef struct packed {
        logic [PAD_W-1:0]           pad;
        logic signed [CROSS_W-1:0]  spread_xy;
        logic [SPREAD_W-1:0]        spread_y;
        logic [SPREAD_W-1:0]        spread_x;
        logic [COORD_W-1:0]         first_y;
        logic [COORD_W-1:0]         first_x;
        logic [COORD_W-1:0]         box_bottom;
        logic [COORD_W-1:0]         box_top;
        logic [COORD_W-1:0]         box_right;
        logic [COORD_W-1:0]         box_left;
        logic [COORD_W-1:0]         centroid_y;
        logic [COORD_W-1:0]         centroid_x;
        logic [AREA_W-1:0]          area;
    } t_result;

endpackage

/* hw/rtl/binary_blob_moments_core.sv */
// Top level of the binary blob moments block: APB register, controller and datapath.
//
// Channel    | Direction | Beat contents
// -----------+-----------+-------------------------------------------------------------
// s (pixel)  | in        | tdata[7:0] pixel_value, tlast frame_end
// m (result) | out       | tdata: area, centroid x/y, box l/r/t/b, first x/y, spreads
// APB        | cfg       | reg 0 at byte 0: image_width[10:0]
//
// Cycles: one pixel beat per clock while accumulating. The beat with tlast is
// followed by the calculation phase (divider load plus 10 restoring divide steps,
// the 9 products of the shared 32x32 multiplier run alongside) and the load of
// the result register; o_s_tready stays low through the calculation and that load.
// If the previous result is still unconsumed, the load waits for i_m_tready.
// A waiting result does not block pixels of the next frame.
// Reset (synchronous, active low) clears the moment accumulators, counters and the result
// valid; image_width returns to 640.
module binary_blob_moments_core #(
    parameter int MAX_DIM = bbm_pkg::BBM_MAX_DIM
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // pixel stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [bbm_pkg::PIX_W-1:0]      i_s_tdata,   // [7:0] pixel_value
    input  logic                           i_s_tlast,   // frame_end
    // result stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [20:0] area, [30:21] centroid_x, [40:31] centroid_y, [50:41] box_left,
    // [60:51] box_right, [70:61] box_top, [80:71] box_bottom, [90:81] first_x,
    // [100:91] first_y, [161:101] spread_x, [222:162] spread_y,
    // [284:223] spread_xy, [287:285] zero
    output logic [bbm_pkg::RES_W-1:0]      o_m_tdata,
    // APB
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic [bbm_pkg::APB_ADDR_W-1:0] i_paddr,
    input  logic [bbm_pkg::APB_DATA_W-1:0] i_pwdata,
    output logic [bbm_pkg::APB_DATA_W-1:0] o_prdata,
    output logic                           o_pready
);
    import bbm_pkg::*;

    // config register; to be written only while idle (the block does not enforce it), so no shadowing
    logic [WIDTH_REG_W-1:0] r_image_width;
    logic                   reg_sel;
    logic                   cfg_wr;

    assign o_pready = 1'b1;
    assign reg_sel  = (i_paddr[2] == REG_IMAGE_WIDTH);
    assign cfg_wr   = i_psel && i_penable && i_pwrite && o_pready && reg_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width <= WIDTH_RESET;
        end else if (cfg_wr) begin
            r_image_width <= i_pwdata[WIDTH_REG_W-1:0];
        end
    end

    assign o_prdata = reg_sel ? APB_DATA_W'(r_image_width) : '0;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    t_result  result;

    bbm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_tvalid),
        .i_s_last  (i_s_tlast),
        .o_s_ready (o_s_tready),
        .o_cmd     (cmd),
        .i_stat    (stat)
    );

    bbm_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_image_width (r_image_width),
        .i_pixel       (i_s_tdata),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_result      (result),
        .o_valid       (o_m_tvalid),
        .i_out_ready   (i_m_tready)
    );

    assign o_m_tdata = result;

endmodule

/* hw/rtl/bbm_ctrl.sv */
// Controller FSM: pixel accumulation, frame-end calculation sequence, result hand-off.
module bbm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_valid,
    input  logic              i_s_last,
    output logic              o_s_ready,
    output bbm_pkg::t_dp_cmd  o_cmd,
    input  bbm_pkg::t_dp_stat i_stat
);
    import bbm_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACCUM;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = '0;
        case (r_state)
            S_ACCUM: begin
                if (i_s_valid && i_s_last) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                if (r_cnt == CALC_LAST) begin
                    n_state = S_OUT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_OUT: begin
                if (!i_stat.out_busy) begin
                    n_state = S_ACCUM;
                end
            end
            default: n_state = S_ACCUM;
        endcase
    end

    // outputs
    always_comb begin
        o_s_ready       = 1'b0;
        o_cmd.acc_en    = 1'b0;
        o_cmd.calc_load = 1'b0;
        o_cmd.div_step  = 1'b0;
        o_cmd.mul_issue = 1'b0;
        o_cmd.mul_op    = OP_X_LO;
        o_cmd.out_load  = 1'b0;
        case (r_state)
            S_ACCUM: begin
                o_s_ready    = 1'b1;
                o_cmd.acc_en = i_s_valid;
            end
            S_CALC: begin
                o_cmd.calc_load = (r_cnt == '0);
                o_cmd.div_step  = (r_cnt != '0);
                o_cmd.mul_issue = (r_cnt < MUL_OPS);
                if (r_cnt < MUL_OPS) begin
                    o_cmd.mul_op = t_mul_op'(r_cnt);
                end
            end
            S_OUT: begin
                o_cmd.out_load = !i_stat.out_busy;
            end
            default: o_s_ready = 1'b0;
        endcase
    end

endmodule

/* hw/rtl/bbm_datapath.sv */
// Datapath: raster counters, moment accumulators, dividers, shared multiplier, result reg.
module bbm_datapath #(
    parameter int MAX_DIM = bbm_pkg::BBM_MAX_DIM
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [bbm_pkg::WIDTH_REG_W-1:0] i_image_width,
    input  logic [bbm_pkg::PIX_W-1:0]       i_pixel,
    input  bbm_pkg::t_dp_cmd                i_cmd,
    output bbm_pkg::t_dp_stat               o_stat,
    output bbm_pkg::t_result                o_result,
    output logic                            o_valid,
    input  logic                            i_out_ready
);
    import bbm_pkg::*;

    localparam logic [WIDTH_REG_W-1:0] MaxDimW   = WIDTH_REG_W'(MAX_DIM);
    localparam logic [COORD_W:0]       RowLimit  = (COORD_W + 1)'(MAX_DIM);
    localparam logic [AREA_W:0]        AreaLimit = (AREA_W + 1)'(MAX_DIM * MAX_DIM);

    // frame state
    logic [COORD_W-1:0] r_col, r_row;
    logic [AREA_W-1:0]  r_area;
    logic [SUM_W-1:0]   r_sum_col, r_sum_row;
    logic [SQ_W-1:0]    r_sq_col, r_sq_row, r_cross;
    logic [COORD_W-1:0] r_min_col, r_max_col, r_min_row, r_max_row;
    logic [COORD_W-1:0] r_start_col, r_start_row;
    logic               r_seen;

    logic [WIDTH_REG_W-1:0] eff_w;
    logic                   col_wrap, row_wrap, hit;
    logic [2*COORD_W-1:0]   col_sq, row_sq, col_row;

    always_comb begin
        if (i_image_width == '0) begin
            eff_w = WIDTH_REG_W'(1);
        end else if (i_image_width > MaxDimW) begin
            eff_w = MaxDimW;
        end else begin
            eff_w = i_image_width;
        end
    end

    assign col_wrap = ({1'b0, r_col} + 1'b1) >= eff_w;
    assign row_wrap = ({1'b0, r_row} + 1'b1) >= RowLimit;
    assign hit      = (i_pixel == OBJECT_PIXEL) && ({1'b0, r_area} < AreaLimit);
    assign col_sq   = r_col * r_col;
    assign row_sq   = r_row * r_row;
    assign col_row  = r_col * r_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.out_load) begin
            r_col       <= '0;
            r_row       <= '0;
            r_area      <= '0;
            r_sum_col   <= '0;
            r_sum_row   <= '0;
            r_sq_col    <= '0;
            r_sq_row    <= '0;
            r_cross     <= '0;
            r_min_col   <= '1;
            r_max_col   <= '0;
            r_min_row   <= '1;
            r_max_row   <= '0;
            r_start_col <= '0;
            r_start_row <= '0;
            r_seen      <= 1'b0;
        end else if (i_cmd.acc_en) begin
            if (hit) begin
                r_area    <= r_area + 1'b1;
                r_sum_col <= r_sum_col + SUM_W'(r_col);
                r_sum_row <= r_sum_row + SUM_W'(r_row);
                r_sq_col  <= r_sq_col + SQ_W'(col_sq);
                r_sq_row  <= r_sq_row + SQ_W'(row_sq);
                r_cross   <= r_cross + SQ_W'(col_row);
                if (r_col < r_min_col) r_min_col <= r_col;
                if (r_col > r_max_col) r_max_col <= r_col;
                if (r_row < r_min_row) r_min_row <= r_row;
                if (r_row > r_max_row) r_max_row <= r_row;
                if (!r_seen) begin
                    r_start_col <= r_col;
                    r_start_row <= r_row;
                    r_seen      <= 1'b1;
                end
            end
            if (col_wrap) begin
                r_col <= '0;
                r_row <= row_wrap ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // centroid dividers: restoring, one quotient bit per step, shared divisor shifter
    logic [SUM_W:0]     r_rem_x, r_rem_y, r_dsor;
    logic [COORD_W-1:0] r_q_x, r_q_y;
    logic               ge_x, ge_y;

    assign ge_x = r_rem_x >= r_dsor;
    assign ge_y = r_rem_y >= r_dsor;

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_load) begin
            r_rem_x <= (SUM_W + 1)'(r_sum_col) + (SUM_W + 1)'(r_area >> 1);
            r_rem_y <= (SUM_W + 1)'(r_sum_row) + (SUM_W + 1)'(r_area >> 1);
            r_dsor  <= (SUM_W + 1)'(r_area) << DIV_SHIFT;
        end else if (i_cmd.div_step) begin
            if (ge_x) r_rem_x <= r_rem_x - r_dsor;
            if (ge_y) r_rem_y <= r_rem_y - r_dsor;
            r_q_x  <= {r_q_x[COORD_W-2:0], ge_x};
            r_q_y  <= {r_q_y[COORD_W-2:0], ge_y};
            r_dsor <= r_dsor >> 1;
        end
    end

    // shared 32x32 multiplier, registered; the product is accumulated in the following cycle
    logic [MUL_W-1:0]   mul_a, mul_b;
    logic [2*MUL_W-1:0] r_prod;
    t_mul_op            r_pop;
    logic               r_pvalid;
    logic [CROSS_W-1:0] prod_term;
    logic [CROSS_W-1:0] r_acc_x, r_acc_y, r_acc_xy;

    always_comb begin
        mul_a = MUL_W'(r_area);
        mul_b = '0;
        case (i_cmd.mul_op)
            OP_X_LO:  mul_b = r_sq_col[MUL_W-1:0];
            OP_X_HI:  mul_b = MUL_W'(r_sq_col[SQ_W-1:MUL_W]);
            OP_X_SQ: begin
                mul_a = MUL_W'(r_sum_col);
                mul_b = MUL_W'(r_sum_col);
            end
            OP_Y_LO:  mul_b = r_sq_row[MUL_W-1:0];
            OP_Y_HI:  mul_b = MUL_W'(r_sq_row[SQ_W-1:MUL_W]);
            OP_Y_SQ: begin
                mul_a = MUL_W'(r_sum_row);
                mul_b = MUL_W'(r_sum_row);
            end
            OP_XY_LO: mul_b = r_cross[MUL_W-1:0];
            OP_XY_HI: mul_b = MUL_W'(r_cross[SQ_W-1:MUL_W]);
            OP_XY_SQ: begin
                mul_a = MUL_W'(r_sum_col);
                mul_b = MUL_W'(r_sum_row);
            end
            default:  mul_b = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= 1'b0;
        end else begin
            r_pvalid <= i_cmd.mul_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= (2 * MUL_W)'(mul_a) * (2 * MUL_W)'(mul_b);
        r_pop  <= i_cmd.mul_op;
    end

    // high half of sum-of-squares carries weight 2^32; everything wraps mod 2^62
    always_comb begin
        if (r_pop inside {OP_X_HI, OP_Y_HI, OP_XY_HI}) begin
            prod_term = {r_prod[CROSS_W-MUL_W-1:0], {MUL_W{1'b0}}};
        end else begin
            prod_term = r_prod[CROSS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_load) begin
            r_acc_x  <= '0;
            r_acc_y  <= '0;
            r_acc_xy <= '0;
        end else if (r_pvalid) begin
            case (r_pop)
                OP_X_LO, OP_X_HI:   r_acc_x  <= r_acc_x + prod_term;
                OP_X_SQ:            r_acc_x  <= r_acc_x - prod_term;
                OP_Y_LO, OP_Y_HI:   r_acc_y  <= r_acc_y + prod_term;
                OP_Y_SQ:            r_acc_y  <= r_acc_y - prod_term;
                OP_XY_LO, OP_XY_HI: r_acc_xy <= r_acc_xy + prod_term;
                OP_XY_SQ:           r_acc_xy <= r_acc_xy - prod_term;
                default:            r_acc_x  <= r_acc_x;
            endcase
        end
    end

    // result register
    t_result n_result, r_result;
    logic    r_valid;

    always_comb begin
        n_result = '0;
        if (r_area != '0) begin
            n_result.area       = r_area;
            n_result.centroid_x = r_q_x;
            n_result.centroid_y = r_q_y;
            n_result.box_left   = r_min_col;
            n_result.box_right  = r_max_col;
            n_result.box_top    = r_min_row;
            n_result.box_bottom = r_max_row;
            n_result.first_x    = r_start_col;
            n_result.first_y    = r_start_row;
            n_result.spread_x   = r_acc_x[SPREAD_W-1:0];
            n_result.spread_y   = r_acc_y[SPREAD_W-1:0];
            n_result.spread_xy  = r_acc_xy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_result <= n_result;
        end
    end

    assign o_stat.out_busy = r_valid && !i_out_ready;
    assign o_result        = r_result;
    assign o_valid         = r_valid;

endmodule

/* hw/rtl/bbm_checker.sv */
// Port-level checker for binary_blob_moments_core, bound to the top level.
module bbm_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic                           i_s_tlast,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [bbm_pkg::RES_W-1:0]      o_m_tdata
);
    import bbm_pkg::*;

    t_result res;
    assign res = o_m_tdata;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result beat changed while stalled");

    // frame end starts the calculation, input stalls next cycle
    a_calc_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tlast |=> !o_s_tready)
        else $error("pixel accepted right after frame end");

    // empty frame reports all zeros
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (res.area == '0) |-> (o_m_tdata == '0))
        else $error("empty frame with nonzero fields");

    // a non-empty frame has an ordered box, first_x within its columns, centroid_y within its rows and a zero pad
    a_box_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (res.area != '0) |->
            (res.box_left <= res.box_right) && (res.box_top <= res.box_bottom) &&
            (res.first_x >= res.box_left) && (res.first_x <= res.box_right) &&
            (res.centroid_y >= res.box_top) && (res.centroid_y <= res.box_bottom) &&
            (res.pad == '0))
        else $error("inconsistent bounding box");

endmodule

bind binary_blob_moments_core bbm_checker u_bbm_checker (.*);

/* verif/testbench.sv */
// Self-checking testbench for binary_blob_moments_core: pixel stream in, frame moments out.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bbm_pkg::*;

    localparam int MAX_DIM       = BBM_MAX_DIM;
    // tlast beat -> calc sequence + result load; leave generous slack
    localparam int SETTLE_CYCLES = 40;
    // long receiver hold-off, long enough to back the block up into its input
    localparam int LONG_HOLD     = 400;
    localparam logic [APB_ADDR_W-1:0] WIDTH_ADDR = APB_ADDR_W'({REG_IMAGE_WIDTH, 2'b00});

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [PIX_W-1:0]      i_s_tdata;   // [7:0] pixel_value
    logic                  i_s_tlast;   // frame_end
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    // [20:0] area, [30:21] centroid_x, [40:31] centroid_y, [50:41] box_left,
    // [60:51] box_right, [70:61] box_top, [80:71] box_bottom, [90:81] first_x,
    // [100:91] first_y, [161:101] spread_x, [222:162] spread_y,
    // [284:223] spread_xy, [287:285] zero
    logic [RES_W-1:0]      o_m_tdata;
    logic                  i_psel;
    logic                  i_penable;
    logic                  i_pwrite;
    logic [APB_ADDR_W-1:0] i_paddr;
    logic [APB_DATA_W-1:0] i_pwdata;
    logic [APB_DATA_W-1:0] o_prdata;
    logic                  o_pready;

    // idle / stall percentages of the current phase
    int   src_idle_pct  = 0;
    int   sink_stall_pct = 0;
    logic long_hold_req = 1'b0;
    int   hold_cnt      = 0;

    binary_blob_moments_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_psel     (i_psel),
        .i_penable  (i_penable),
        .i_pwrite   (i_pwrite),
        .i_paddr    (i_paddr),
        .i_pwdata   (i_pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready)
    );

    // ------------------------------------------------------------------
    // Moment predictor and result checker. Keeps its own copy of the
    // width register, raster counters and per-frame accumulators.
    // ------------------------------------------------------------------
    class blob_moment_checker;
        logic [WIDTH_REG_W-1:0] width_reg;
        logic [COORD_W-1:0]     col_pos, row_pos;
        logic [AREA_W-1:0]      obj_count;
        logic [SUM_W-1:0]       sum_x, sum_y;
        logic [SQ_W-1:0]        sum_xx, sum_yy, sum_xy;
        logic [COORD_W-1:0]     box_l, box_r, box_t, box_b;
        logic [COORD_W-1:0]     first_col, first_row;
        logic                   found;
        t_result                moments_due[$];
        int                     errors;
        int                     beats;
        int                     frames_checked;
        int                     width_writes;

        function new();
            width_reg      = WIDTH_RESET;
            errors         = 0;
            beats          = 0;
            frames_checked = 0;
            width_writes   = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            col_pos   = '0;
            row_pos   = '0;
            obj_count = '0;
            sum_x     = '0;
            sum_y     = '0;
            sum_xx    = '0;
            sum_yy    = '0;
            sum_xy    = '0;
            box_l     = '1;
            box_r     = '0;
            box_t     = '1;
            box_b     = '0;
            first_col = '0;
            first_row = '0;
            found     = 1'b0;
        endfunction

        function void load_width(logic [WIDTH_REG_W-1:0] w);
            width_reg = w;
            width_writes++;
        endfunction

        function int outstanding();
            return moments_due.size();
        endfunction

        function void note_pixel(logic [PIX_W-1:0] pix, logic last);
            int          eff;
            t_result     want;
            logic [63:0] a;
            // out-of-range widths clamp to 1..MAX_DIM
            eff = (width_reg == 0) ? 1 :
                  ((int'(width_reg) > MAX_DIM) ? MAX_DIM : int'(width_reg));
            beats++;
            // area saturates at MAX_DIM^2; later object pixels are dropped
            if (pix == OBJECT_PIXEL && int'(obj_count) < MAX_DIM * MAX_DIM) begin
                obj_count++;
                sum_x  += col_pos;
                sum_y  += row_pos;
                sum_xx += SQ_W'(col_pos) * SQ_W'(col_pos);
                sum_yy += SQ_W'(row_pos) * SQ_W'(row_pos);
                sum_xy += SQ_W'(col_pos) * SQ_W'(row_pos);
                if (col_pos < box_l) box_l = col_pos;
                if (col_pos > box_r) box_r = col_pos;
                if (row_pos < box_t) box_t = row_pos;
                if (row_pos > box_b) box_b = row_pos;
                if (!found) begin
                    first_col = col_pos;
                    first_row = row_pos;
                    found     = 1'b1;
                end
            end
            if (int'(col_pos) + 1 >= eff) begin
                col_pos = '0;
                row_pos = (int'(row_pos) + 1 >= MAX_DIM) ? '0 : row_pos + 1'b1;
            end else begin
                col_pos++;
            end
            if (!last) return;
            want = '0;
            if (obj_count != 0) begin
                a               = 64'(obj_count);
                want.area       = obj_count;
                want.centroid_x = COORD_W'((64'(sum_x) + a / 2) / a);
                want.centroid_y = COORD_W'((64'(sum_y) + a / 2) / a);
                want.box_left   = box_l;
                want.box_right  = box_r;
                want.box_top    = box_t;
                want.box_bottom = box_b;
                want.first_x    = first_col;
                want.first_y    = first_row;
                want.spread_x   = SPREAD_W'(a * 64'(sum_xx) - 64'(sum_x) * 64'(sum_x));
                want.spread_y   = SPREAD_W'(a * 64'(sum_yy) - 64'(sum_y) * 64'(sum_y));
                want.spread_xy  = CROSS_W'(a * 64'(sum_xy) - 64'(sum_x) * 64'(sum_y));
            end
            moments_due = {moments_due, want};
            clear_frame();
        endfunction

        function void compare_field(string field, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, field, want, got);
            end
        endfunction

        function void check_result(logic [RES_W-1:0] beat);
            t_result want;
            t_result got;
            got = t_result'(beat);
            if (moments_due.size() == 0) begin
                errors++;
                $display("%0t: result beat with no frame pending, expected none, actual 0x%0h",
                         $time, beat);
                return;
            end
            want = moments_due.pop_front();
            frames_checked++;
            compare_field("area",       want.area,       got.area);
            compare_field("centroid_x", want.centroid_x, got.centroid_x);
            compare_field("centroid_y", want.centroid_y, got.centroid_y);
            compare_field("box_left",   want.box_left,   got.box_left);
            compare_field("box_right",  want.box_right,  got.box_right);
            compare_field("box_top",    want.box_top,    got.box_top);
            compare_field("box_bottom", want.box_bottom, got.box_bottom);
            compare_field("first_x",    want.first_x,    got.first_x);
            compare_field("first_y",    want.first_y,    got.first_y);
            compare_field("spread_x",   want.spread_x,   got.spread_x);
            compare_field("spread_y",   want.spread_y,   got.spread_y);
            compare_field("spread_xy",  want.spread_xy,  got.spread_xy);
            compare_field("pad",        '0,              got.pad);
        endfunction
    endclass

    blob_moment_checker sb;

    // ------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit: a full run finishes well within it even with a result per beat
    initial begin
        #2_000_000;
        $display("FAIL binary_blob_moments_core");
        $finish;
    end

    // ------------------------------------------------------------------
    // Beat monitor: everything is sampled at the edge where it is taken.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) sb.note_pixel(i_s_tdata, i_s_tlast);
            if (o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata);
        end
    end

    // Result receiver: random stalls, plus one long hold-off on request that
    // is counted here so the sender can keep pushing in the meantime.
    initial begin
        forever begin
            @(posedge i_clk);
            if (long_hold_req && hold_cnt < LONG_HOLD) begin
                hold_cnt++;
                i_m_tready <= 1'b0;
            end else begin
                if (!long_hold_req) hold_cnt = 0;
                i_m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // One pixel beat; called on a clock edge, returns on the edge that took it.
    task automatic put_pixel(input logic [PIX_W-1:0] pix, input logic last);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= pix;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // Mostly object / background, some odd grey levels that must not count.
    function automatic logic [PIX_W-1:0] random_pixel();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return OBJECT_PIXEL;
        if (r < 85) return '0;
        return PIX_W'($urandom_range(0, 255));
    endfunction

    // Stop offering, wait for every pending result, then let the calc pipe settle.
    // One edge first so the monitor has logged the last beat.
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Setup + access phase; pready is expected high but still honored.
    task automatic reg_access(input logic wr, input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= wr;
        i_paddr   <= WIDTH_ADDR;
        i_pwdata  <= wdata;
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        rdata = o_prdata;
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write image_width, mirror it into the predictor and read it back.
    task automatic set_width(input logic [WIDTH_REG_W-1:0] w);
        logic [APB_DATA_W-1:0] rd;
        reg_access(1'b1, APB_DATA_W'(w), rd);
        sb.load_width(w);
        reg_access(1'b0, '0, rd);
        if (rd[WIDTH_REG_W-1:0] !== w) begin
            sb.errors++;
            $display("%0t: image_width readback mismatch, expected 0x%0h, actual 0x%0h",
                     $time, w, rd[WIDTH_REG_W-1:0]);
        end
    endtask

    // Random frames of random length; a phase may stop mid-frame, so the next
    // width write lands inside an open frame.
    task automatic run_phase(input int n_beats, input int idle_pct, input int stall_pct);
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        repeat (n_beats) put_pixel(random_pixel(), $urandom_range(0, 9) == 0);
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main
        logic [PIX_W-1:0]       grey_mix[9];
        logic [APB_DATA_W-1:0]  rd;
        logic [WIDTH_REG_W-1:0] w;
        int                     idle_sel[4];
        int                     stall_sel[4];

        grey_mix  = '{8'd255, 8'd0, 8'd254, 8'd255, 8'd255, 8'd128, 8'd1, 8'd127, 8'd255};
        idle_sel  = '{0, 71, 0, 11};
        stall_sel = '{0, 0, 71, 11};
        sb = new();

        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tlast  <= 1'b0;
        i_m_tready <= 1'b0;
        i_psel     <= 1'b0;
        i_penable  <= 1'b0;
        i_pwrite   <= 1'b0;
        i_paddr    <= '0;
        i_pwdata   <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // width register comes out of reset at 640
        reg_access(1'b0, '0, rd);
        if (rd[WIDTH_REG_W-1:0] !== WIDTH_RESET) begin
            sb.errors++;
            $display("%0t: image_width reset mismatch, expected 0x%0h, actual 0x%0h",
                     $time, WIDTH_RESET, rd[WIDTH_REG_W-1:0]);
        end

        // --- directed ---
        // empty frame, then a lone object pixel at the origin
        put_pixel('0, 1'b1);
        put_pixel(OBJECT_PIXEL, 1'b1);
        wait_drained();

        // narrow image, near-miss grey values must not count as object
        set_width(11'd3);
        foreach (grey_mix[i]) put_pixel(grey_mix[i], i == 8);
        wait_drained();

        // zero width behaves as one column
        set_width(11'd0);
        put_pixel(OBJECT_PIXEL, 1'b0);
        put_pixel(OBJECT_PIXEL, 1'b0);
        put_pixel('0, 1'b0);
        put_pixel(OBJECT_PIXEL, 1'b1);
        wait_drained();

        // all-ones width clamps to MAX_DIM
        set_width(11'h7FF);
        put_pixel(8'd1, 1'b0);
        put_pixel(OBJECT_PIXEL, 1'b1);
        wait_drained();

        // --- back-pressure: receiver holds off while short frames keep coming ---
        set_width(11'd2);
        long_hold_req <= 1'b1;
        for (int i = 0; i < 40; i++) put_pixel(random_pixel(), (i % 4) == 3);
        wait_drained();
        long_hold_req <= 1'b0;

        // --- random phases, each idling pattern twice with fresh widths ---
        for (int p = 0; p < 8; p++) begin
            case ($urandom_range(0, 9))
                0:       w = 11'd0;
                1:       w = 11'd1;
                2:       w = 11'h7FF;
                3:       w = 11'd1024;
                4:       w = 11'd1025;
                5:       w = 11'd1023;
                default: w = WIDTH_REG_W'($urandom_range(2, 9));
            endcase
            set_width(w);
            run_phase(60, idle_sel[p % 4], stall_sel[p % 4]);
        end

        // close whatever frame the last phase left open
        put_pixel('0, 1'b1);
        wait_drained();

        if (sb.outstanding() != 0) begin
            sb.errors++;
            $display("%0t: %0d frame results never arrived", $time, sb.outstanding());
        end

        $display("Covered %0d pixel beats, %0d frame results, %0d width writes",
                 sb.beats, sb.frames_checked, sb.width_writes);
        $display("Included empty, clamped-width, mid-frame width and back-pressured frames");
        if (sb.errors == 0) begin
            $display("PASS binary_blob_moments_core");
        end else begin
            $display("FAIL binary_blob_moments_core");
        end
        $finish;
    end

endmodule
